// ===== rtl/core/servo_slew_accel_limiter_macros.svh =====
// Assertion macros shared by the servo slew and acceleration limiter.
`ifndef SERVO_SLEW_ACCEL_LIMITER_MACROS_SVH
`define SERVO_SLEW_ACCEL_LIMITER_MACROS_SVH

// Assert that an antecedent implies a consequent on the next cycle.
`define SSAL_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// Assert that an antecedent implies a consequent in the same cycle.
`define SSAL_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/ssal_pkg.sv =====
// Package with types and constants of the servo slew and acceleration limiter.
`default_nettype none
package ssal_pkg;
  localparam int FracBits = 8;
  localparam int PosW = 12 + FracBits;     // unsigned position
  localparam int VelW = 23 + FracBits;     // signed saturated velocity
  localparam int WideW = 48;               // signed working width
  localparam int CfgW = 20;

  localparam logic [2:0] RegInMin = 3'd0;
  localparam logic [2:0] RegInMax = 3'd1;
  localparam logic [2:0] RegOutMin = 3'd2;
  localparam logic [2:0] RegOutMax = 3'd3;
  localparam logic [2:0] RegSpeed = 3'd4;
  localparam logic [2:0] RegAccel = 3'd5;

  // Datapath operations issued by the controller.
  typedef enum logic [3:0] {
    OpNone   = 4'd0,
    OpJump   = 4'd1,
    OpMapMul = 4'd2,  // (p - in_min) * orange
    OpMapDiv = 4'd3,  // start divide by irange
    OpMapEnd = 4'd4,  // target done, error formed
    OpErrMul = 4'd5,  // err * 1000 and accel * ms
    OpDesDiv = 4'd6,  // start desired = err*1000 / ms
    OpDesEnd = 4'd7,  // clamp desired by speed
    OpAccDiv = 4'd8,  // start dmax = accel*ms / 1000
    OpAccEnd = 4'd9,  // apply dv, saturate, multiply by ms
    OpPosDiv = 4'd10, // start step = v*ms / 1000
    OpPosEnd = 4'd11  // integrate, clamp, snap
  } op_t;

  typedef struct packed {
    op_t op;
  } ctrl_cmd_t;

  typedef struct packed {
    logic div_done;
    logic map_empty;  // input range empty: target is out_min
    logic no_limits;
    logic small_err;  // |err| <= half
    logic accel_on;
  } ctrl_sts_t;
endpackage
`default_nettype wire

// ===== rtl/core/ssal_div.sv =====
// Sequential signed dividers truncating toward zero: radix-2 and divide-by-1000.
`default_nettype none
module ssal_div (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic start,
  input  wire logic signed [ssal_pkg::WideW-1:0] dividend,
  input  wire logic [ssal_pkg::WideW-1:0] divisor,
  output logic done,
  output logic signed [ssal_pkg::WideW-1:0] quotient
);
  import ssal_pkg::*;
  localparam int CntW = $clog2(WideW + 1);

  logic busy;
  logic [CntW-1:0] count;
  logic [WideW-1:0] num;
  logic [WideW-1:0] rem;
  logic [WideW-1:0] den;
  logic neg;
  logic [WideW:0] trial;

  assign trial = {rem, num[WideW-1]} - {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        count <= CntW'(WideW);
      end else if (busy) begin
        count <= count - 1'b1;
        if (count == CntW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      neg <= dividend[WideW-1];
      num <= dividend[WideW-1] ? WideW'(-dividend) : WideW'(dividend);
      rem <= '0;
      den <= divisor;
    end else if (busy) begin
      if (!trial[WideW]) begin
        rem <= trial[WideW-1:0];
        num <= {num[WideW-2:0], 1'b1};
      end else begin
        rem <= {rem[WideW-2:0], num[WideW-1]};
        num <= {num[WideW-2:0], 1'b0};
      end
    end
  end

  assign quotient = neg ? -$signed(num) : $signed(num);
endmodule

module ssal_div1000 (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic start,
  input  wire logic signed [ssal_pkg::WideW-1:0] dividend,
  output logic done,
  output logic signed [ssal_pkg::WideW-1:0] quotient
);
  import ssal_pkg::*;
  // Long division in base 65536; each digit step divides a value below 2^26
  // by 1000 through a reciprocal that is exact over that range.
  localparam logic [26:0] Recip = 27'd68719477;
  localparam logic [9:0] Kilo = 10'd1000;

  logic [1:0] count;
  logic [WideW-1:0] num;
  logic [WideW-1:0] quo_mag;
  logic [9:0] rem;
  logic neg;
  logic [25:0] part;
  logic [52:0] scaled;
  logic [15:0] digit;
  logic [25:0] back;

  assign part = {rem, num[WideW-1 -: 16]};
  assign scaled = part * Recip;
  assign digit = scaled[51:36];
  assign back = part - 26'(digit) * 26'(Kilo);

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        count <= 2'd3;
      end else if (count != 2'd0) begin
        count <= count - 2'd1;
        if (count == 2'd1) done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      neg <= dividend[WideW-1];
      num <= dividend[WideW-1] ? WideW'(-dividend) : WideW'(dividend);
      rem <= '0;
      quo_mag <= '0;
    end else if (count != 2'd0) begin
      num <= {num[WideW-17:0], 16'd0};
      rem <= back[9:0];
      quo_mag <= {quo_mag[WideW-17:0], digit};
    end
  end

  assign quotient = neg ? -$signed(quo_mag) : $signed(quo_mag);
endmodule
`default_nettype wire

// ===== rtl/core/ssal_ctrl.sv =====
// Controller state machine sequencing one item through the datapath.
`default_nettype none
module ssal_ctrl (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_fire,
  input  wire logic command,
  input  wire logic ms_zero,
  input  wire logic out_fire,
  input  wire ssal_pkg::ctrl_sts_t sts,
  output ssal_pkg::ctrl_cmd_t cmd,
  output logic in_ready,
  output logic out_load,
  output logic out_updated
);
  import ssal_pkg::*;

  typedef enum logic [12:0] {
    SIdle   = 13'b0000000000001,
    SMapMul = 13'b0000000000010,
    SMapDiv = 13'b0000000000100,
    SMapW   = 13'b0000000001000,
    SErrMul = 13'b0000000010000,
    SDesDiv = 13'b0000000100000,
    SDesW   = 13'b0000001000000,
    SAccDiv = 13'b0000010000000,
    SAccW   = 13'b0000100000000,
    SApply  = 13'b0001000000000,
    SPosDiv = 13'b0010000000000,
    SPosW   = 13'b0100000000000,
    SOut    = 13'b1000000000000
  } state_t;

  state_t state, state_next;
  logic out_full;
  logic upd_next;

  assign in_ready = (state == SIdle) && !out_full;

  always_comb begin
    state_next = state;
    cmd.op = OpNone;
    out_load = 1'b0;
    upd_next = 1'b1;
    case (state)
      SIdle: begin
        if (in_fire) begin
          if (command) begin
            cmd.op = OpJump;
            out_load = 1'b1;
          end else if (ms_zero) begin
            out_load = 1'b1;
            upd_next = 1'b0;
          end else begin
            state_next = SMapMul;
          end
        end
      end
      SMapMul: begin cmd.op = OpMapMul; state_next = SMapDiv; end
      SMapDiv: begin cmd.op = OpMapDiv; state_next = SMapW; end
      SMapW: begin
        if (sts.div_done || sts.map_empty) begin
          cmd.op = OpMapEnd;
          state_next = SErrMul;
        end
      end
      SErrMul: begin
        if (sts.no_limits) begin
          cmd.op = OpPosEnd;
          state_next = SOut;
        end else begin
          cmd.op = OpErrMul;
          state_next = sts.small_err ? SDesW : SDesDiv;
        end
      end
      SDesDiv: begin cmd.op = OpDesDiv; state_next = SDesW; end
      SDesW: begin
        if (sts.small_err || sts.div_done) begin
          cmd.op = OpDesEnd;
          state_next = sts.accel_on ? SAccDiv : SApply;
        end
      end
      SAccDiv: begin cmd.op = OpAccDiv; state_next = SAccW; end
      SAccW: if (sts.div_done) state_next = SApply;
      SApply: begin cmd.op = OpAccEnd; state_next = SPosDiv; end
      SPosDiv: begin cmd.op = OpPosDiv; state_next = SPosW; end
      SPosW: begin
        if (sts.div_done) begin
          cmd.op = OpPosEnd;
          state_next = SOut;
        end
      end
      SOut: begin
        out_load = 1'b1;
        state_next = SIdle;
      end
      default: state_next = SIdle;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= SIdle;
      out_full <= 1'b0;
      out_updated <= 1'b0;
    end else begin
      state <= state_next;
      if (out_load) begin
        out_full <= 1'b1;
        out_updated <= upd_next;
      end else if (out_fire) begin
        out_full <= 1'b0;
      end
    end
  end
endmodule
`default_nettype wire

// ===== rtl/core/ssal_dp.sv =====
// Datapath: registers, one multiplier stage, a shared divider and a divide-by-1000 unit.
`default_nettype none
module ssal_dp (
  input  wire logic clk,
  input  wire logic rst,
  input  wire ssal_pkg::ctrl_cmd_t cmd,
  input  wire logic cfg_we,
  input  wire logic [2:0] cfg_idx,
  input  wire logic [ssal_pkg::CfgW-1:0] cfg_data,
  input  wire logic in_fire,
  input  wire logic [11:0] in_pulse,
  input  wire logic [9:0] in_ms,
  input  wire logic [11:0] in_jump,
  output ssal_pkg::ctrl_sts_t sts,
  output logic [11:0] pos_int,
  output logic [11:0] tgt,
  output logic signed [22:0] vel_int
);
  import ssal_pkg::*;
  localparam logic signed [WideW-1:0] Half = WideW'(1) <<< (FracBits - 1);
  localparam logic signed [WideW-1:0] VelHi = (WideW'(1) <<< (VelW - 1)) - 1;
  localparam logic signed [WideW-1:0] VelLo = -(WideW'(1) <<< (VelW - 1));

  logic [11:0] in_min, in_max, out_min, out_max;
  logic [15:0] speed;
  logic [19:0] accel;
  logic [11:0] pulse;
  logic [9:0] ms;
  logic [PosW-1:0] pos;
  logic signed [VelW-1:0] vel;
  logic signed [WideW-1:0] err, desired, prod, prod2, dmax;
  logic div_start;
  logic signed [WideW-1:0] div_a;
  logic [WideW-1:0] div_b;
  logic div_done;
  logic signed [WideW-1:0] quo;
  logic kd_start;
  logic signed [WideW-1:0] kd_a;
  logic kd_done;
  logic signed [WideW-1:0] kquo;

  logic [11:0] p_cl, jmp_cl;
  logic signed [13:0] irange, orange;
  logic signed [WideW-1:0] tgt_fx, pos_w, vel_w, dv, vsum, vsat, npos, vmax;
  logic signed [WideW-1:0] lo_fx, hi_fx, nclamp, diff;
  logic signed [WideW-1:0] tsum, tcl;
  logic [11:0] tmap;

  always_comb begin
    p_cl = (in_pulse < in_min) ? in_min : in_pulse;
    p_cl = (pulse < in_min) ? in_min : pulse;
    if (p_cl > in_max) p_cl = in_max;
    jmp_cl = (in_jump < out_min) ? out_min : in_jump;
    if (jmp_cl > out_max) jmp_cl = out_max;
    irange = $signed({2'b0, in_max}) - $signed({2'b0, in_min});
    orange = $signed({2'b0, out_max}) - $signed({2'b0, out_min});
    tgt_fx = $signed(WideW'(tgt)) <<< FracBits;
    pos_w = $signed(WideW'(pos));
    vel_w = WideW'(vel);
    vmax = $signed(WideW'(speed)) <<< FracBits;
    lo_fx = $signed(WideW'(out_min)) <<< FracBits;
    hi_fx = $signed(WideW'(out_max)) <<< FracBits;
    // Map result: out_min plus quotient, raised to the minimum, then lowered to the maximum.
    tsum = $signed(WideW'(out_min)) + quo;
    tcl = tsum;
    if (tcl < $signed(WideW'(out_min))) tcl = $signed(WideW'(out_min));
    if (tcl > $signed(WideW'(out_max))) tcl = $signed(WideW'(out_max));
    tmap = tcl[11:0];
    if (sts.map_empty) tmap = out_min;
    dv = desired - vel_w;
    if (dv < -dmax) dv = -dmax;
    if (dv > dmax) dv = dmax;
    vsum = sts.accel_on ? vel_w + dv : desired;
    vsat = vsum;
    if (vsat < VelLo) vsat = VelLo;
    if (vsat > VelHi) vsat = VelHi;
    npos = pos_w + kquo;
    nclamp = npos;
    if (nclamp < lo_fx) nclamp = lo_fx;
    if (nclamp > hi_fx) nclamp = hi_fx;
    diff = tgt_fx - nclamp;
  end

  assign sts.div_done = div_done | kd_done;
  assign sts.map_empty = (irange <= 0);
  assign sts.no_limits = (speed == '0) && (accel == '0);
  assign sts.small_err = (err <= Half) && (err >= -Half);
  assign sts.accel_on = (accel != '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      in_min <= 12'd1000;
      in_max <= 12'd2000;
      out_min <= 12'd1000;
      out_max <= 12'd2000;
      speed <= '0;
      accel <= '0;
      pos <= '0;
      vel <= '0;
      tgt <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_idx)
          RegInMin: in_min <= cfg_data[11:0];
          RegInMax: in_max <= cfg_data[11:0];
          RegOutMin: out_min <= cfg_data[11:0];
          RegOutMax: out_max <= cfg_data[11:0];
          RegSpeed: speed <= cfg_data[15:0];
          RegAccel: accel <= cfg_data[19:0];
          default: ;
        endcase
      end
      case (cmd.op)
        OpJump: begin
          pos <= PosW'(jmp_cl) << FracBits;
          tgt <= jmp_cl;
          vel <= '0;
        end
        OpMapEnd: tgt <= tmap;
        OpAccEnd: vel <= VelW'(vsat);
        OpPosEnd: begin
          if (sts.no_limits) begin
            pos <= PosW'(tgt) << FracBits;
            vel <= '0;
          end else if (diff < Half && diff > -Half) begin
            pos <= PosW'(tgt) << FracBits;
            vel <= '0;
          end else begin
            pos <= PosW'(nclamp);
          end
        end
        default: ;
      endcase
    end
  end

  // Operand registers; the widest multiply is the 31-bit velocity by the 10-bit ms.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      pulse <= in_pulse;
      ms <= in_ms;
    end
    case (cmd.op)
      OpMapMul: prod <= WideW'($signed({2'b0, p_cl}) - $signed({2'b0, in_min})) *
                        WideW'(orange);
      OpMapEnd: err <= ($signed(WideW'(tmap)) <<< FracBits) - pos_w;
      OpErrMul: begin
        prod <= err * $signed(WideW'(1000));
        prod2 <= $signed(WideW'(accel)) * $signed(WideW'(ms));
        desired <= '0;
      end
      OpDesEnd: begin
        if (!sts.small_err) begin
          desired <= quo;
          if (speed != '0) begin
            if (quo < -vmax) desired <= -vmax;
            if (quo > vmax) desired <= vmax;
          end
        end
      end
      OpAccEnd: prod <= vsat * $signed(WideW'(ms));
      default: ;
    endcase
    if (kd_done && (cmd.op == OpNone)) dmax <= kquo;
  end

  // Variable divisors go to the radix-2 divider, the divisions by 1000 to their own unit.
  always_comb begin
    div_start = 1'b0;
    div_a = prod;
    div_b = WideW'(ms);
    kd_start = 1'b0;
    kd_a = prod;
    case (cmd.op)
      OpMapDiv: begin div_start = !sts.map_empty; div_b = WideW'(irange); end
      OpDesDiv: div_start = 1'b1;
      OpAccDiv: begin kd_start = 1'b1; kd_a = prod2 <<< FracBits; end
      OpPosDiv: kd_start = 1'b1;
      default: ;
    endcase
  end

  ssal_div u_div (
    .clk(clk), .rst(rst), .start(div_start), .dividend(div_a), .divisor(div_b),
    .done(div_done), .quotient(quo)
  );

  ssal_div1000 u_kdiv (
    .clk(clk), .rst(rst), .start(kd_start), .dividend(kd_a),
    .done(kd_done), .quotient(kquo)
  );

  assign pos_int = pos[PosW-1:FracBits];
  // Truncate toward zero when dropping the fraction.
  assign vel_int = 23'((vel + ((vel < 0) ? VelW'((1 << FracBits) - 1) : VelW'(0)))
                       >>> FracBits);
endmodule
`default_nettype wire

// ===== rtl/core/servo_slew_accel_limiter.sv =====
// Jumps and skipped ticks load the result straight from the idle state. A tick runs
// up to two passes of a radix-2 divider and two passes of a divide-by-1000 unit; with
// no limits and a valid input range it runs only the map pass of the radix-2 divider.
// One item at a time: the next item is taken once the result register is free.
// The result register parts the output stall from the controller.
// Reset: synchronous, active high; ranges 1000..2000, limits zero, state zero.
`default_nettype none
`include "servo_slew_accel_limiter_macros.svh"
module servo_slew_accel_limiter (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic cfg_we,
  input  wire logic [2:0] cfg_index,
  input  wire logic [ssal_pkg::CfgW-1:0] cfg_data,
  input  wire logic in_valid,
  output logic in_stall,
  input  wire logic command,
  input  wire logic [11:0] input_pulse_us,
  input  wire logic [9:0] elapsed_ms,
  input  wire logic [11:0] jump_position_us,
  output logic out_valid,
  input  wire logic out_stall,
  output logic [11:0] pos_us,
  output logic [11:0] target_us,
  output logic signed [22:0] velocity,
  output logic updated
);
  import ssal_pkg::*;

  ctrl_cmd_t cmd;
  ctrl_sts_t sts;
  logic in_ready, in_fire, out_fire, out_load, upd;
  logic [11:0] pos_int, tgt;
  logic signed [22:0] vel_int;

  assign in_stall = !in_ready;
  assign in_fire = in_valid && in_ready;
  assign out_fire = out_valid && !out_stall;

  ssal_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_fire(in_fire), .command(command),
    .ms_zero(elapsed_ms == '0), .out_fire(out_fire), .sts(sts), .cmd(cmd),
    .in_ready(in_ready), .out_load(out_load), .out_updated(upd)
  );

  ssal_dp u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .cfg_we(cfg_we), .cfg_idx(cfg_index),
    .cfg_data(cfg_data), .in_fire(in_fire), .in_pulse(input_pulse_us),
    .in_ms(elapsed_ms), .in_jump(jump_position_us), .sts(sts),
    .pos_int(pos_int), .tgt(tgt), .vel_int(vel_int)
  );

  // Result register: loaded the cycle after the controller finishes.
  logic load_q;
  always_ff @(posedge clk) begin
    if (rst) begin
      load_q <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      load_q <= out_load;
      if (load_q) out_valid <= 1'b1;
      else if (out_fire) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_q) begin
      pos_us <= pos_int;
      target_us <= tgt;
      velocity <= vel_int;
      updated <= upd;
    end
  end

  `SSAL_ASSERT_NEXT(a_no_accept_while_busy, in_fire, in_stall,
                    "item accepted while another is in flight")
  `SSAL_ASSERT_NOW(a_load_only_when_free, load_q, !out_valid,
                   "result overwritten before it was taken")
  `SSAL_ASSERT_NEXT(a_load_follows, out_load, load_q,
                    "result load lost")
endmodule
`default_nettype wire
